/* rtl/ajr_pkg.sv */
// Shared types and constants for the auto joypad read sequencer.
package ajr_pkg;

    localparam int STEP_W    = 6;
    localparam int LAST_STEP = 34;
    localparam int PAD_COUNT = 4;
    localparam int PAD_W     = 16;
    localparam int SEL_W     = 3;
    localparam int DATA_W    = 8;

    localparam logic [STEP_W-1:0] STEP_MAX  = {STEP_W{1'b1}};
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(LAST_STEP);

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              strobe_level;
        logic              busy_flag;
    } t_result;

endpackage

/* rtl/auto_joypad_read_sequencer_core.sv */
// Top level of the auto joypad read sequencer.
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one operation per
//   transaction: start a frame sequence, a tick with both ports' data lines,
//   a write of the auto-read enable bit, or a read of one byte of the four
//   16-bit pad words.
//   Output channel (o_out_valid / i_out_ready) returns one transaction per
//   operation: the read byte (zero for non-reads), the strobe level and the
//   busy flag as they stand after the operation.
// Result: registered, valid in the cycle after the input transaction.
// Throughput: 1 operation per cycle unless the receiver stalls; the state update
//   and result selection fit in one combinational pass ahead of the result register.
// Reset: synchronous, active low; clears the step counter, all flags, the
//   port latches and the pad words, and empties the result register.
// Stall: while a result waits and i_out_ready is low, o_in_ready is low and
//   the result holds; a result taken in the same cycle frees the register.
module auto_joypad_read_sequencer_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [1:0]                i_operation,
    input  logic [1:0]                i_port_one_lines,
    input  logic [1:0]                i_port_two_lines,
    input  logic                      i_enable_value,
    input  logic [ajr_pkg::SEL_W-1:0] i_register_select,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [ajr_pkg::DATA_W-1:0] o_read_data,
    output logic                      o_strobe_level,
    output logic                      o_busy_flag
);
    import ajr_pkg::*;

    logic    accept;   // input transaction taken this cycle
    logic    out_free; // result register can load
    t_result core_result;
    t_result out_result;

    assign o_in_ready = out_free;
    assign accept     = i_in_valid && out_free;

    // State update happens at the accepting edge; result is next-state view
    ajr_core u_core (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (accept),
        .i_operation      (i_operation),
        .i_port_one_lines (i_port_one_lines),
        .i_port_two_lines (i_port_two_lines),
        .i_enable_value   (i_enable_value),
        .i_register_select(i_register_select),
        .o_result         (core_result)
    );

    ajr_out_reg u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (i_in_valid),
        .i_result(core_result),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_free  (out_free),
        .o_result(out_result)
    );

    assign o_read_data    = out_result.read_data;
    assign o_strobe_level = out_result.strobe_level;
    assign o_busy_flag    = out_result.busy_flag;

endmodule

/* rtl/ajr_core.sv */
// Sequencer state and its registered update for each accepted operation.
module ajr_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [1:0]          i_operation,
    input  logic [1:0]          i_port_one_lines,
    input  logic [1:0]          i_port_two_lines,
    input  logic                i_enable_value,
    input  logic [ajr_pkg::SEL_W-1:0] i_register_select,
    output ajr_pkg::t_result    o_result
);
    import ajr_pkg::*;

    logic [STEP_W-1:0] r_step, n_step;
    logic              r_started, n_started;
    logic              r_stopped, n_stopped;
    logic              r_busy, n_busy;
    logic              r_strobe, n_strobe;
    logic              r_enable, n_enable;
    logic [1:0]        r_latch_one, n_latch_one;
    logic [1:0]        r_latch_two, n_latch_two;
    logic [PAD_W-1:0]  r_pad [PAD_COUNT];
    logic [PAD_W-1:0]  n_pad [PAD_COUNT];

    logic [STEP_W-1:0] step_eff;
    logic [STEP_W-1:0] step_inc;
    logic [PAD_W-1:0]  sel_word;

    assign step_inc = (r_step == STEP_MAX) ? r_step : r_step + 1'b1;
    // Enable dropped from step 3 on jumps straight to the end of the sequence
    assign step_eff = (r_step >= STEP_W'(3) && !r_enable) ? STEP_LAST : r_step;
    assign sel_word = r_pad[i_register_select[SEL_W-1:1]];

    always_comb begin
        n_step      = r_step;
        n_started   = r_started;
        n_stopped   = r_stopped;
        n_busy      = r_busy;
        n_strobe    = r_strobe;
        n_enable    = r_enable;
        n_latch_one = r_latch_one;
        n_latch_two = r_latch_two;
        for (int i = 0; i < PAD_COUNT; i++) begin
            n_pad[i] = r_pad[i];
        end
        o_result.read_data = '0;

        unique case (i_operation)
            OP_START: begin
                n_step    = '0;
                n_started = 1'b1;
                n_stopped = 1'b0;
            end
            OP_TICK: begin
                if (r_started) begin
                    if (r_stopped) begin
                        if (r_step >= STEP_W'(2)) n_strobe = 1'b0;
                        n_step = step_inc;
                    end else begin
                        if (r_step == STEP_W'(0)) begin
                            n_strobe = r_enable;
                        end else if (r_step == STEP_W'(1)) begin
                            if (!r_enable) begin
                                n_stopped = 1'b1;
                                n_busy    = 1'b0;
                            end else begin
                                n_busy = 1'b1;
                                for (int i = 0; i < PAD_COUNT; i++) begin
                                    n_pad[i] = '0;
                                end
                            end
                        end else if (r_step == STEP_W'(2)) begin
                            n_strobe = 1'b0;
                        end else if (!r_enable) begin
                            // no port activity, halt below
                        end else if (r_step[0]) begin
                            n_latch_one = i_port_one_lines;
                            n_latch_two = i_port_two_lines;
                        end else begin
                            n_pad[0] = {r_pad[0][PAD_W-2:0], r_latch_one[0]};
                            n_pad[1] = {r_pad[1][PAD_W-2:0], r_latch_two[0]};
                            n_pad[2] = {r_pad[2][PAD_W-2:0], r_latch_one[1]};
                            n_pad[3] = {r_pad[3][PAD_W-2:0], r_latch_two[1]};
                        end
                        if (step_eff >= STEP_LAST) begin
                            n_stopped = 1'b1;
                            n_busy    = 1'b0;
                            n_strobe  = 1'b0;
                        end else begin
                            n_step = step_inc;
                        end
                    end
                end
            end
            OP_WRITE: begin
                // strobe follows enable during steps 1 and 2
                if (i_enable_value != r_enable && r_started &&
                    (r_step == STEP_W'(1) || r_step == STEP_W'(2))) begin
                    n_strobe = i_enable_value;
                end
                n_enable = i_enable_value;
                if (!i_enable_value && r_started && !r_stopped &&
                    r_step >= STEP_W'(4)) begin
                    n_stopped = 1'b1;
                    n_busy    = 1'b0;
                    n_strobe  = 1'b0;
                end
            end
            OP_READ: begin
                o_result.read_data = i_register_select[0] ? sel_word[PAD_W-1:DATA_W]
                                                          : sel_word[DATA_W-1:0];
            end
            default: ;
        endcase

        o_result.strobe_level = n_strobe;
        o_result.busy_flag    = n_busy;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_started   <= 1'b0;
            r_stopped   <= 1'b0;
            r_busy      <= 1'b0;
            r_strobe    <= 1'b0;
            r_enable    <= 1'b0;
            r_latch_one <= '0;
            r_latch_two <= '0;
            for (int i = 0; i < PAD_COUNT; i++) begin
                r_pad[i] <= '0;
            end
        end else if (i_accept) begin
            r_step      <= n_step;
            r_started   <= n_started;
            r_stopped   <= n_stopped;
            r_busy      <= n_busy;
            r_strobe    <= n_strobe;
            r_enable    <= n_enable;
            r_latch_one <= n_latch_one;
            r_latch_two <= n_latch_two;
            for (int i = 0; i < PAD_COUNT; i++) begin
                r_pad[i] <= n_pad[i];
            end
        end
    end

endmodule

/* rtl/ajr_out_reg.sv */
// Result register with valid/ready handshake toward the receiver.
module ajr_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  ajr_pkg::t_result i_result,
    input  logic             i_ready,
    output logic             o_valid,
    output logic             o_free,
    output ajr_pkg::t_result o_result
);
    import ajr_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_free   = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && o_free) begin
            r_result <= i_result;
        end
    end

endmodule

/* rtl/ajr_checker.sv */
// Port-level checker for the auto joypad read sequencer, with its bind.
module ajr_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_in_valid,
    input logic                      o_in_ready,
    input logic [1:0]                i_operation,
    input logic                      o_out_valid,
    input logic                      i_out_ready,
    input logic [ajr_pkg::DATA_W-1:0] o_read_data,
    input logic                      o_strobe_level,
    input logic                      o_busy_flag
);
    import ajr_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted operation produced no result");

    a_nonread_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && i_operation != OP_READ |=> o_read_data == '0)
        else $error("non-read operation returned nonzero data");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_read_data)
            && $stable(o_strobe_level) && $stable(o_busy_flag))
        else $error("stalled result changed");

endmodule

bind auto_joypad_read_sequencer_core ajr_checker u_ajr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .i_operation   (i_operation),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_read_data   (o_read_data),
    .o_strobe_level(o_strobe_level),
    .o_busy_flag   (o_busy_flag)
);

/* tb/sv/auto_joypad_read_sequencer_core_chk.sv */
// Channel monitor, pad poller prediction and result comparison.
module auto_joypad_read_sequencer_core_chk (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [1:0]                 i_operation,
    input  logic [1:0]                 i_port_one_lines,
    input  logic [1:0]                 i_port_two_lines,
    input  logic                       i_enable_value,
    input  logic [ajr_pkg::SEL_W-1:0]  i_register_select,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic [ajr_pkg::DATA_W-1:0] i_read_data,
    input  logic                       i_strobe_level,
    input  logic                       i_busy_flag,
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ajr_pkg::*;

    // shadow of the poller
    logic [STEP_W-1:0] step_q;
    logic              seq_started;
    logic              seq_stopped;
    logic              busy_q;
    logic              strobe_q;
    logic              enable_q;
    logic [1:0]        latch_p1;
    logic [1:0]        latch_p2;
    logic [PAD_W-1:0]  pad_word [PAD_COUNT];

    t_result poll_results_q[$];

    task automatic clear_poller();
        step_q      = '0;
        seq_started = 1'b0;
        seq_stopped = 1'b0;
        busy_q      = 1'b0;
        strobe_q    = 1'b0;
        enable_q    = 1'b0;
        latch_p1    = '0;
        latch_p2    = '0;
        foreach (pad_word[i]) pad_word[i] = '0;
    endtask

    task automatic halt_poll();
        seq_stopped = 1'b1;
        busy_q      = 1'b0;
        strobe_q    = 1'b0;
    endtask

    task automatic poll_tick(input logic [1:0] p1, input logic [1:0] p2);
        int s;
        if (!seq_started) return;
        if (seq_stopped) begin
            // stopped: counter still runs (saturating), strobe forced low from step 2
            if (step_q >= 2) strobe_q = 1'b0;
            if (step_q != STEP_MAX) step_q = step_q + 1'b1;
            return;
        end
        s = int'(step_q);
        if (s == 0) begin
            strobe_q = enable_q;
        end else if (s == 1) begin
            if (!enable_q) begin
                seq_stopped = 1'b1;
                busy_q      = 1'b0;
            end else begin
                busy_q = 1'b1;
                foreach (pad_word[i]) pad_word[i] = '0;
            end
        end else if (s == 2) begin
            strobe_q = 1'b0;
        end else if (!enable_q) begin
            s = LAST_STEP;
        end else if (s % 2 == 1) begin
            latch_p1 = p1;
            latch_p2 = p2;
        end else begin
            pad_word[0] = {pad_word[0][PAD_W-2:0], latch_p1[0]};
            pad_word[1] = {pad_word[1][PAD_W-2:0], latch_p2[0]};
            pad_word[2] = {pad_word[2][PAD_W-2:0], latch_p1[1]};
            pad_word[3] = {pad_word[3][PAD_W-2:0], latch_p2[1]};
        end
        if (s >= LAST_STEP) halt_poll();
        else if (step_q != STEP_MAX) step_q = step_q + 1'b1;
    endtask

    task automatic predict_poll(input logic [1:0] op, input logic [1:0] p1,
                                input logic [1:0] p2, input logic en,
                                input logic [SEL_W-1:0] sel);
        t_result r;
        logic [PAD_W-1:0] word;
        r.read_data = '0;
        case (op)
            OP_START: begin
                step_q      = '0;
                seq_started = 1'b1;
                seq_stopped = 1'b0;
            end
            OP_TICK: poll_tick(p1, p2);
            OP_WRITE: begin
                // strobe follows the enable bit during steps 1 and 2
                if (en != enable_q && seq_started && (step_q == 1 || step_q == 2))
                    strobe_q = en;
                enable_q = en;
                if (!en && seq_started && !seq_stopped && step_q >= 4) halt_poll();
            end
            default: begin
                word        = pad_word[sel[2:1]];
                r.read_data = sel[0] ? word[15:8] : word[7:0];
            end
        endcase
        r.strobe_level = strobe_q;
        r.busy_flag    = busy_q;
        poll_results_q.push_back(r);
    endtask

    task automatic note_mismatch(input string field, input int exp_v, input int act_v);
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, exp_v, act_v);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            clear_poller();
            poll_results_q.delete();
        end else begin
            // result side first: an item taken at this edge cannot have its result yet
            if (i_out_valid && i_out_ready) begin
                if (poll_results_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none actual data %0d strobe %0d busy %0d",
                             $time, i_read_data, i_strobe_level, i_busy_flag);
                    o_fail_count++;
                end else begin
                    exp_r = poll_results_q.pop_front();
                    if (i_read_data !== exp_r.read_data)
                        note_mismatch("read_data", exp_r.read_data, i_read_data);
                    if (i_strobe_level !== exp_r.strobe_level)
                        note_mismatch("strobe_level", exp_r.strobe_level, i_strobe_level);
                    if (i_busy_flag !== exp_r.busy_flag)
                        note_mismatch("busy_flag", exp_r.busy_flag, i_busy_flag);
                end
            end
            if (i_in_valid && i_in_ready)
                predict_poll(i_operation, i_port_one_lines, i_port_two_lines,
                             i_enable_value, i_register_select);
        end
        o_pending = poll_results_q.size();
    end

endmodule

/* tb/sv/auto_joypad_read_sequencer_core_tb.sv */
// Top of the auto joypad read sequencer testbench: clock, reset, stimulus, verdict.
module auto_joypad_read_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ajr_pkg::*;

    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_PCT     = 9;
    // leave lots of headroom over the slowest legal run
    localparam int CYCLE_LIMIT  = 300000;
    // window of transactions where neither side idles
    localparam int CALM_FROM    = 700;
    localparam int CALM_TO      = 1000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_operation = OP_READ;
    logic [1:0]        i_port_one_lines = '0;
    logic [1:0]        i_port_two_lines = '0;
    logic              i_enable_value = 1'b0;
    logic [SEL_W-1:0]  i_register_select = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [DATA_W-1:0] o_read_data;
    logic              o_strobe_level;
    logic              o_busy_flag;

    int fail_count;
    int pending;
    int cycle_count = 0;
    int sent = 0;
    bit calm = 1'b0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    auto_joypad_read_sequencer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_port_one_lines (i_port_one_lines),
        .i_port_two_lines (i_port_two_lines),
        .i_enable_value   (i_enable_value),
        .i_register_select(i_register_select),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_read_data      (o_read_data),
        .o_strobe_level   (o_strobe_level),
        .o_busy_flag      (o_busy_flag)
    );

    auto_joypad_read_sequencer_core_chk chk (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .i_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_port_one_lines (i_port_one_lines),
        .i_port_two_lines (i_port_two_lines),
        .i_enable_value   (i_enable_value),
        .i_register_select(i_register_select),
        .i_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .i_read_data      (o_read_data),
        .i_strobe_level   (o_strobe_level),
        .i_busy_flag      (o_busy_flag),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // Result-side backpressure: ready drops at random with an IDLE_PCT percent chance, never in the calm window.
    always @(posedge i_clk) begin
        if (calm) i_out_ready <= 1'b1;
        else      i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("auto_joypad_read_sequencer_core test failed");
            $finish;
        end
    end

    // One input transaction. Valid may drop for random idle edges first; once raised
    // it stays up with a stable payload until the edge where ready is seen high.
    // Valid is never lowered here after acceptance, so a back-to-back transaction
    // keeps it high without two assignments in one time step.
    task automatic send_op(input logic [1:0] op, input logic [1:0] p1, input logic [1:0] p2,
                           input logic en, input logic [SEL_W-1:0] sel);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid        <= 1'b1;
        i_operation       <= op;
        i_port_one_lines  <= p1;
        i_port_two_lines  <= p2;
        i_enable_value    <= en;
        i_register_select <= sel;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sent++;
    endtask

    // Unused fields of each operation carry random bits so every input bit toggles.
    task automatic tick(input logic [1:0] p1, input logic [1:0] p2);
        send_op(OP_TICK, p1, p2, 1'($urandom), SEL_W'($urandom));
    endtask

    task automatic write_enable(input logic en);
        send_op(OP_WRITE, 2'($urandom), 2'($urandom), en, SEL_W'($urandom));
    endtask

    task automatic read_byte(input logic [SEL_W-1:0] sel);
        send_op(OP_READ, 2'($urandom), 2'($urandom), 1'($urandom), sel);
    endtask

    task automatic start_frame();
        send_op(OP_START, 2'($urandom), 2'($urandom), 1'($urandom), SEL_W'($urandom));
    endtask

    // Mostly a clean frame: enable, start, enough ticks to reach the final step,
    // then read back all eight pad bytes. Sprinkled reads catch partial words;
    // rare enable writes and restarts break the sequence at random steps.
    task automatic run_frame();
        int n_ticks;
        int k;
        if ($urandom_range(99) < 80) write_enable(1'b1);
        start_frame();
        n_ticks = LAST_STEP + 1 + $urandom_range(0, 4);
        for (k = 0; k < n_ticks; k++) begin
            if ($urandom_range(99) < 12) read_byte(SEL_W'($urandom));
            if ($urandom_range(199) < 3) write_enable(1'($urandom));
            else if ($urandom_range(199) == 0) start_frame();
            tick(2'($urandom), 2'($urandom));
        end
        for (k = 0; k < 8; k++) read_byte(SEL_W'(k));
    endtask

    // Noise: a short burst of fully random operations, or now and then a long
    // run of ticks that pushes a stopped step counter into saturation.
    task automatic run_noise();
        if ($urandom_range(19) == 0) begin
            repeat (70) tick(2'($urandom), 2'($urandom));
        end else begin
            repeat ($urandom_range(1, 8))
                send_op(2'($urandom), 2'($urandom), 2'($urandom), 1'($urandom),
                        SEL_W'($urandom));
        end
    endtask

    initial begin
        int target;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        read_byte(SEL_W'(0));                 // pad words are zero out of reset
        tick(2'd3, 2'd3);                     // tick before any start does nothing
        write_enable(1'b0);
        start_frame();
        tick(2'd0, 2'd0);                     // step 0: strobe takes enable (low)
        tick(2'd0, 2'd0);                     // step 1 with enable off: stops
        tick(2'd3, 2'd3);                     // stopped, counter still runs
        tick(2'd3, 2'd3);                     // stopped past step 2: strobe forced low
        write_enable(1'b1);
        start_frame();
        tick(2'd0, 2'd0);                     // step 0: strobe high
        write_enable(1'b0);                   // early window: strobe follows at once
        write_enable(1'b1);
        tick(2'd0, 2'd0);                     // step 1: busy set, pad words cleared
        start_frame();                        // restart while running keeps busy
        read_byte(SEL_W'(7));
        tick(2'd0, 2'd0);                     // step 0
        tick(2'd0, 2'd0);                     // step 1
        tick(2'd0, 2'd0);                     // step 2: strobe drops
        tick(2'd3, 2'd0);                     // latch
        tick(2'd0, 2'd3);                     // shift
        tick(2'd0, 2'd3);                     // latch
        tick(2'd3, 2'd0);                     // shift
        read_byte(SEL_W'(3));                 // partial word during the sequence
        write_enable(1'b0);                   // enable off from step 4 on: immediate stop
        read_byte(SEL_W'(4));

        // ---- random ----
        target = sent + RANDOM_ITEMS;
        while (sent < target) begin
            calm = (sent >= CALM_FROM && sent < CALM_TO);
            if ($urandom_range(99) < 75) run_frame();
            else                         run_noise();
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        // drain outstanding results, then keep watching for strays
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("auto_joypad_read_sequencer_core test passed");
        end else begin
            $display("auto_joypad_read_sequencer_core test failed");
        end
        $finish;
    end

endmodule
